@@ rtl/lbmw_pkg.sv @@
// Shared types, constants and fixed-point helpers for the moving-wall closure.
// No dependencies; lbm_moving_wall_closure, lbmw_cfg, lbmw_div and lbmw_tail import this package.
`timescale 1ns / 1ps

package lbmw_pkg;

    // Q4.28 signed fixed point.
    localparam int FRAC_BITS = 28;

    // APB register map: four 32-bit registers at byte addresses 4*i.
    localparam int ADDR_W   = 4;
    localparam int NUM_REGS = 4;

    typedef enum logic [1:0] {
        REG_BOT_U = 2'd0,
        REG_BOT_V = 2'd1,
        REG_TOP_U = 2'd2,
        REG_TOP_V = 2'd3
    } reg_idx_t;

    // Wide signed word for intermediate sums before saturation.
    typedef logic signed [47:0] wide_t;

    localparam logic signed [31:0] SMAX  = 32'sh7fff_ffff;
    localparam logic signed [31:0] SMIN  = 32'sh8000_0000;
    localparam wide_t              ONE_W = wide_t'(1) <<< FRAC_BITS;

    // Product of two Q words after scaling down.
    localparam int MULQ_W = 64 - FRAC_BITS;

    // Divider: signed dividend width, quotient bits, low dividend bits that
    // start out in the shift word rather than in the partial remainder.
    localparam int DVD_W   = 36;
    localparam int DIV_QW  = 33;
    localparam int DIV_PRE = DIV_QW - FRAC_BITS;
    localparam logic [DIV_QW-1:0] QLIM = DIV_QW'(1) << 31;

    // Reciprocal of nine: floor(y/9) = (y * RECIP9) >> RECIP_SHIFT for y < 2^35.
    localparam int                RECIP_SHIFT = 38;
    localparam logic [34:0]       RECIP9      = 35'd30541989661;
    localparam int                SPLIT       = 18;

    typedef struct packed {
        logic signed [31:0] bot_u;
        logic signed [31:0] bot_v;
        logic signed [31:0] top_u;
        logic signed [31:0] top_v;
    } wall_cfg_t;

    // Values that ride alongside the dividers.
    typedef struct packed {
        logic signed [31:0]       u;
        logic signed [31:0]       v;
        logic signed [MULQ_W-1:0] vvq;
        logic signed [MULQ_W-1:0] uvq;
        logic signed [33:0]       sum3;
        logic signed [33:0]       diff;
        logic signed [31:0]       rho;
        logic signed [31:0]       m;
        logic                     ov;
    } side_t;

    // Inputs of the polynomial and output section.
    typedef struct packed {
        logic signed [31:0]       w;
        logic signed [31:0]       e;
        logic signed [31:0]       d;
        logic signed [31:0]       v;
        logic signed [MULQ_W-1:0] vvq;
        logic signed [31:0]       rho;
        logic                     ov;
    } tail_t;

    function automatic logic sat_ov(input wide_t x);
        return (x > wide_t'(SMAX)) || (x < wide_t'(SMIN));
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t x);
        logic signed [31:0] r;
        if (x > wide_t'(SMAX))
            r = SMAX;
        else if (x < wide_t'(SMIN))
            r = SMIN;
        else
            r = x[31:0];
        return r;
    endfunction

    // Scale a full product down by 2^FRAC_BITS, truncating toward zero.
    function automatic logic signed [MULQ_W-1:0] qtrunc(input logic signed [63:0] p);
        logic signed [MULQ_W-1:0] q;
        q = p[63:FRAC_BITS];
        if (p[63] && (p[FRAC_BITS-1:0] != '0))
            q = q + MULQ_W'(1);
        return q;
    endfunction

endpackage

@@ rtl/lbmw_if.sv @@
// Stream interfaces of the wall closure: node input and closure result.
// Plain valid/ready channels; no package dependency.
`timescale 1ns / 1ps

interface lbmw_node_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] f_rest;
    logic signed [31:0] f_east;
    logic signed [31:0] f_west;
    logic signed [31:0] f_normal_out;
    logic signed [31:0] f_diag_out_east;
    logic signed [31:0] f_diag_out_west;

    modport source (output valid, mode, f_rest, f_east, f_west, f_normal_out,
                    f_diag_out_east, f_diag_out_west, input ready);
    modport sink   (input valid, mode, f_rest, f_east, f_west, f_normal_out,
                    f_diag_out_east, f_diag_out_west, output ready);
endinterface

interface lbmw_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] f_normal_in;
    logic signed [31:0] f_diag_in_east;
    logic signed [31:0] f_diag_in_west;
    logic               overflow;

    modport source (output valid, f_normal_in, f_diag_in_east, f_diag_in_west,
                    overflow, input ready);
    modport sink   (input valid, f_normal_in, f_diag_in_east, f_diag_in_west,
                    overflow, output ready);
endinterface

@@ rtl/lbm_moving_wall_closure.sv @@
// Top level of the D2Q9 moving-wall closure: front stages, four dividers,
// tail and output register. Depends on lbmw_pkg, lbmw_if, lbmw_cfg,
// lbmw_div and lbmw_tail.
//
// Usage. Wall nodes arrive on the node channel as a transaction carrying the
// wall side (mode) and the six known distributions. Each node gives exactly
// one transaction on the result channel with the three inward distributions
// and an overflow flag, in the same order as the nodes arrived.
// The plate velocities live in four APB registers (bottom u, bottom v, top u,
// top v at byte addresses 0, 4, 8, 12); write them while no node is in flight.
//
// Throughput is one node per clock unless a stalled result freezes the
// pipeline. It holds four chained dividers at 35 stages each (33 quotient
// bits, an entry stage and a saturation stage).
//
// Reset clears every valid bit and the registers, so the pipeline comes up
// empty with zero wall velocities. When the receiver stalls, the result
// register holds its transaction; the pipeline behind it keeps moving while
// its last stage is empty, and otherwise the whole pipeline freezes and
// node.ready drops. Nothing is lost or duplicated across a stall.
`timescale 1ns / 1ps

module lbm_moving_wall_closure
    import lbmw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lbmw_node_if.sink         node,
    lbmw_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    wall_cfg_t cfg;

    // One advance enable for every stage. The pipeline may move whenever the
    // result register can take data or there is nothing at its far end.
    logic adv;
    logic tail_vld;
    logic res_vld_reg;

    assign adv        = result.ready | ~res_vld_reg | ~tail_vld;
    assign node.ready = adv;

    lbmw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Stage 0: wall velocity select, known-population sum, first divisor.
    // ------------------------------------------------------------------
    logic signed [31:0] u_sel;
    logic signed [31:0] v_sel;
    wide_t              s3_w;
    wide_t              known_w;
    wide_t              den1_w;
    wide_t              diff_w;
    side_t              s0_side_next;

    logic               s0_vld_reg;
    logic signed [31:0] s0_known_reg;
    logic signed [31:0] s0_den_reg;
    side_t              s0_side_reg;

    always_comb
    begin
        u_sel   = node.mode ? cfg.top_u : cfg.bot_u;
        v_sel   = node.mode ? cfg.top_v : cfg.bot_v;
        s3_w    = wide_t'(node.f_normal_out) + wide_t'(node.f_diag_out_east)
                  + wide_t'(node.f_diag_out_west);
        known_w = wide_t'(node.f_rest) + wide_t'(node.f_east) + wide_t'(node.f_west)
                  + s3_w + s3_w;
        den1_w  = ONE_W - wide_t'(v_sel);
        diff_w  = wide_t'(node.f_east) - wide_t'(node.f_west)
                  + wide_t'(node.f_diag_out_east) - wide_t'(node.f_diag_out_west);

        s0_side_next      = '0;
        s0_side_next.u    = u_sel;
        s0_side_next.v    = v_sel;
        s0_side_next.sum3 = s3_w[33:0];
        s0_side_next.diff = diff_w[33:0];
        s0_side_next.ov   = sat_ov(known_w) | sat_ov(den1_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (adv)
            s0_vld_reg <= node.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_known_reg <= sat32(known_w);
            s0_den_reg   <= sat32(den1_w);
            s0_side_reg  <= s0_side_next;
        end
    end

    // Wall density rhow.
    logic               d1_vld;
    logic signed [31:0] d1_quo;
    logic               d1_ov;
    side_t              d1_side;

    lbmw_div u_div_rhow (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s0_vld_reg),
        .dividend  (DVD_W'(s0_known_reg)),
        .divisor   (s0_den_reg),
        .side_in   (s0_side_reg),
        .out_valid (d1_vld),
        .quotient  (d1_quo),
        .q_ov      (d1_ov),
        .side_out  (d1_side)
    );

    // ------------------------------------------------------------------
    // Stage 1: the four products rhow*v, rhow*u, v*v and u*v.
    // ------------------------------------------------------------------
    logic               s1_vld_reg;
    logic signed [63:0] s1_prv_reg;
    logic signed [63:0] s1_pru_reg;
    logic signed [63:0] s1_pvv_reg;
    logic signed [63:0] s1_puv_reg;
    side_t              s1_side_reg;
    side_t              s1_side_next;

    always_comb
    begin
        s1_side_next     = d1_side;
        s1_side_next.rho = d1_quo;
        s1_side_next.ov  = d1_side.ov | d1_ov;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= d1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prv_reg  <= 64'(d1_quo) * 64'(d1_side.v);
            s1_pru_reg  <= 64'(d1_quo) * 64'(d1_side.u);
            s1_pvv_reg  <= 64'(d1_side.v) * 64'(d1_side.v);
            s1_puv_reg  <= 64'(d1_side.u) * 64'(d1_side.v);
            s1_side_reg <= s1_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: momentum term t, second divisor, tangential momentum m.
    // ------------------------------------------------------------------
    logic signed [MULQ_W-1:0] rvq;
    logic signed [MULQ_W-1:0] ruq;
    wide_t                    t_w;
    wide_t                    den2_w;
    wide_t                    m_w;
    side_t                    s2_side_next;

    logic                     s2_vld_reg;
    logic signed [DVD_W-1:0]  s2_dvd_reg;
    logic signed [31:0]       s2_den_reg;
    side_t                    s2_side_reg;

    always_comb
    begin
        rvq    = qtrunc(s1_prv_reg);
        ruq    = qtrunc(s1_pru_reg);
        s2_side_next     = s1_side_reg;
        s2_side_next.vvq = qtrunc(s1_pvv_reg);
        s2_side_next.uvq = qtrunc(s1_puv_reg);
        t_w    = wide_t'(rvq) + wide_t'(s1_side_reg.sum3);
        den2_w = ONE_W + 3 * wide_t'(s1_side_reg.v) + 3 * wide_t'(s2_side_next.vvq);
        m_w    = wide_t'(ruq) - wide_t'(s1_side_reg.diff);
        s2_side_next.m  = sat32(m_w);
        s2_side_next.ov = s1_side_reg.ov | sat_ov(t_w) | sat_ov(den2_w) | sat_ov(m_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (adv)
            s2_vld_reg <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_dvd_reg  <= DVD_W'(wide_t'(sat32(t_w)) * 6);
            s2_den_reg  <= sat32(den2_w);
            s2_side_reg <= s2_side_next;
        end
    end

    // Corrected density rhop.
    logic               d2_vld;
    logic signed [31:0] d2_quo;
    logic               d2_ov;
    side_t              d2_side;
    side_t              d3_side_in;

    lbmw_div u_div_rhop (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s2_vld_reg),
        .dividend  (s2_dvd_reg),
        .divisor   (s2_den_reg),
        .side_in   (s2_side_reg),
        .out_valid (d2_vld),
        .quotient  (d2_quo),
        .q_ov      (d2_ov),
        .side_out  (d2_side)
    );

    always_comb
    begin
        d3_side_in     = d2_side;
        d3_side_in.rho = d2_quo;
        d3_side_in.ov  = d2_side.ov | d2_ov;
    end

    // Slip ratio s = 6m / rhop, fed straight from the previous quotient.
    logic               d3_vld;
    logic signed [31:0] d3_quo;
    logic               d3_ov;
    side_t              d3_side;

    lbmw_div u_div_slip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (d2_vld),
        .dividend  (DVD_W'(wide_t'(d2_side.m) * 6)),
        .divisor   (d2_quo),
        .side_in   (d3_side_in),
        .out_valid (d3_vld),
        .quotient  (d3_quo),
        .q_ov      (d3_ov),
        .side_out  (d3_side)
    );

    // ------------------------------------------------------------------
    // Stage 4: numerator and divisor of the slip velocity.
    // ------------------------------------------------------------------
    wide_t              n_w;
    wide_t              den3_w;
    side_t              s4_side_next;

    logic               s4_vld_reg;
    logic signed [31:0] s4_dvd_reg;
    logic signed [31:0] s4_den_reg;
    side_t              s4_side_reg;

    always_comb
    begin
        n_w    = wide_t'(d3_quo) - wide_t'(d3_side.u) - 3 * wide_t'(d3_side.uvq);
        den3_w = ONE_W + 3 * wide_t'(d3_side.v);
        s4_side_next    = d3_side;
        s4_side_next.ov = d3_side.ov | d3_ov | sat_ov(n_w) | sat_ov(den3_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (adv)
            s4_vld_reg <= d3_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_dvd_reg  <= sat32(n_w);
            s4_den_reg  <= sat32(den3_w);
            s4_side_reg <= s4_side_next;
        end
    end

    // Slip velocity upx.
    logic               d4_vld;
    logic signed [31:0] d4_quo;
    logic               d4_ov;
    side_t              d4_side;

    lbmw_div u_div_upx (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s4_vld_reg),
        .dividend  (DVD_W'(s4_dvd_reg)),
        .divisor   (s4_den_reg),
        .side_in   (s4_side_reg),
        .out_valid (d4_vld),
        .quotient  (d4_quo),
        .q_ov      (d4_ov),
        .side_out  (d4_side)
    );

    // ------------------------------------------------------------------
    // Stage 5: total tangential velocity w and the two diagonal speeds.
    // ------------------------------------------------------------------
    wide_t              w_w;
    logic signed [31:0] w_sat;
    wide_t              e_w;
    wide_t              dg_w;
    tail_t              s5_next;

    logic               s5_vld_reg;
    tail_t              s5_reg;

    always_comb
    begin
        w_w   = wide_t'(d4_side.u) + wide_t'(d4_quo);
        w_sat = sat32(w_w);
        e_w   = wide_t'(w_sat) + wide_t'(d4_side.v);
        dg_w  = wide_t'(d4_side.v) - wide_t'(w_sat);
        s5_next.w   = w_sat;
        s5_next.e   = sat32(e_w);
        s5_next.d   = sat32(dg_w);
        s5_next.v   = d4_side.v;
        s5_next.vvq = d4_side.vvq;
        s5_next.rho = d4_side.rho;
        s5_next.ov  = d4_side.ov | d4_ov | sat_ov(w_w) | sat_ov(e_w) | sat_ov(dg_w);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_vld_reg <= 1'b0;
        else if (adv)
            s5_vld_reg <= d4_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s5_reg <= s5_next;
    end

    // Polynomials and the scaled inward distributions.
    logic signed [31:0] t_normal;
    logic signed [31:0] t_east;
    logic signed [31:0] t_west;
    logic               t_ov;

    lbmw_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s5_vld_reg),
        .din       (s5_reg),
        .out_valid (tail_vld),
        .f_normal  (t_normal),
        .f_east    (t_east),
        .f_west    (t_west),
        .ov        (t_ov)
    );

    // ------------------------------------------------------------------
    // Result register: holds a transaction until the receiver takes it.
    // ------------------------------------------------------------------
    logic signed [31:0] res_n_reg;
    logic signed [31:0] res_e_reg;
    logic signed [31:0] res_w_reg;
    logic               res_ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (result.ready || !res_vld_reg)
            res_vld_reg <= tail_vld;
    end

    always_ff @(posedge clk)
    begin
        if (result.ready || !res_vld_reg)
        begin
            res_n_reg  <= t_normal;
            res_e_reg  <= t_east;
            res_w_reg  <= t_west;
            res_ov_reg <= t_ov;
        end
    end

    assign result.valid          = res_vld_reg;
    assign result.f_normal_in    = res_n_reg;
    assign result.f_diag_in_east = res_e_reg;
    assign result.f_diag_in_west = res_w_reg;
    assign result.overflow       = res_ov_reg;

endmodule

@@ rtl/lbmw_cfg.sv @@
// APB register file holding the two plate velocities.
// Depends on lbmw_pkg.
`timescale 1ns / 1ps

module lbmw_cfg
    import lbmw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output wall_cfg_t         cfg
);

    logic [31:0] cfg_reg [NUM_REGS];
    logic [1:0]  idx;

    assign idx    = paddr[ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = cfg_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                cfg_reg[i] <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            cfg_reg[idx] <= pwdata;
        end
    end

    assign cfg.bot_u = cfg_reg[REG_BOT_U];
    assign cfg.bot_v = cfg_reg[REG_BOT_V];
    assign cfg.top_u = cfg_reg[REG_TOP_U];
    assign cfg.top_v = cfg_reg[REG_TOP_V];

endmodule

@@ rtl/lbmw_div.sv @@
// Pipelined saturating fixed-point divider, one quotient bit per stage.
// Depends on lbmw_pkg; carries a side_t record along with each quotient.
`timescale 1ns / 1ps

module lbmw_div
    import lbmw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic signed [31:0]      divisor,
    input  side_t                   side_in,
    output logic                    out_valid,
    output logic signed [31:0]      quotient,
    output logic                    q_ov,
    output side_t                   side_out
);

    logic [DIV_QW:0]   vld_reg;
    logic [31:0]       rem_reg  [DIV_QW+1];
    logic [DIV_QW-1:0] wrd_reg  [DIV_QW+1];
    logic [31:0]       dsr_reg  [DIV_QW+1];
    logic [DIV_QW:0]   neg_reg;
    logic [DIV_QW:0]   big_reg;
    side_t             side_reg [DIV_QW+1];

    logic [DVD_W-1:0]  mag_next;
    logic [31:0]       dsr_next;
    logic              big_next;

    logic                   out_vld_reg;
    logic signed [31:0]     quo_reg;
    logic                   ov_reg;
    side_t                  side_o_reg;
    logic [DIV_QW-1:0]      qraw;
    logic                   hi_next;
    logic signed [31:0]     quo_next;

    // Entry: magnitudes and the early overflow test. A zero divisor always
    // lands in the overflow case, which saturates by the dividend's sign.
    always_comb
    begin
        mag_next = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
        dsr_next = divisor[31] ? 32'(-divisor) : 32'(divisor);
        big_next = (mag_next >> DIV_PRE) >= DVD_W'(dsr_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg     <= {vld_reg[DIV_QW-1:0], in_valid};
            out_vld_reg <= vld_reg[DIV_QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= 32'(mag_next >> DIV_PRE);
            wrd_reg[0]  <= {mag_next[DIV_PRE-1:0], FRAC_BITS'(0)};
            dsr_reg[0]  <= dsr_next;
            neg_reg[0]  <= dividend[DVD_W-1] ^ divisor[31];
            big_reg[0]  <= big_next;
            side_reg[0] <= side_in;
        end
    end

    for (genvar k = 0; k < DIV_QW; k++)
    begin : g_step
        logic [32:0] trial;
        logic        ge;

        assign trial = {rem_reg[k], wrd_reg[k][DIV_QW-1]};
        assign ge    = trial >= {1'b0, dsr_reg[k]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? 32'(trial - {1'b0, dsr_reg[k]}) : trial[31:0];
                wrd_reg[k+1]  <= {wrd_reg[k][DIV_QW-2:0], ge};
                dsr_reg[k+1]  <= dsr_reg[k];
                neg_reg[k+1]  <= neg_reg[k];
                big_reg[k+1]  <= big_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    // Sign and saturation of the finished quotient.
    always_comb
    begin
        qraw    = wrd_reg[DIV_QW];
        hi_next = neg_reg[DIV_QW] ? (qraw > QLIM) : (qraw >= QLIM);
        if (big_reg[DIV_QW] || hi_next)
            quo_next = neg_reg[DIV_QW] ? SMIN : SMAX;
        else if (neg_reg[DIV_QW])
            quo_next = 32'(~qraw + DIV_QW'(1));
        else
            quo_next = qraw[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg    <= quo_next;
            ov_reg     <= big_reg[DIV_QW] | hi_next;
            side_o_reg <= side_reg[DIV_QW];
        end
    end

    assign out_valid = out_vld_reg;
    assign quotient  = quo_reg;
    assign q_ov      = ov_reg;
    assign side_out  = side_o_reg;

endmodule

@@ rtl/lbmw_tail.sv @@
// Equilibrium polynomials and the three inward distributions, five stages.
// Depends on lbmw_pkg.
`timescale 1ns / 1ps

module lbmw_tail
    import lbmw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  tail_t              din,
    output logic               out_valid,
    output logic signed [31:0] f_normal,
    output logic signed [31:0] f_east,
    output logic signed [31:0] f_west,
    output logic               ov
);

    logic [4:0] vld_reg;

    // Stage 1: squares of w, e and d.
    logic signed [63:0]       sq_reg [3];
    tail_t                    t1_reg;

    // Stage 2: polynomials for the normal, east and west directions.
    logic signed [31:0]       poly_reg [3];
    logic signed [31:0]       rho2_reg;
    logic                     ov2_reg;
    logic signed [MULQ_W-1:0] sqq [3];
    logic signed [31:0]       px [3];
    logic signed [MULQ_W-1:0] pxx [3];
    wide_t                    c15_w;
    logic signed [31:0]       c15;
    wide_t                    poly_w [3];
    logic                     ov2_next;

    // Stage 3: density times polynomial.
    logic signed [63:0]       prod_reg [3];
    logic                     ov3_reg;

    // Stage 4 and 5: reciprocal multiply for /9 and /36.
    logic [51:0]              ph_reg [3];
    logic [52:0]              pl_reg [3];
    logic [2:0]               neg_reg;
    logic                     ov4_reg;
    logic signed [31:0]       res_reg [3];
    logic                     ov5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0] <= 64'(din.w) * 64'(din.w);
            sq_reg[1] <= 64'(din.e) * 64'(din.e);
            sq_reg[2] <= 64'(din.d) * 64'(din.d);
            t1_reg    <= din;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sqq[i] = qtrunc(sq_reg[i]);
        // Squares are never negative, so halving is a plain shift.
        c15_w  = (3 * (wide_t'(sqq[0]) + wide_t'(t1_reg.vvq))) >>> 1;
        c15    = sat32(c15_w);
        px[0]  = t1_reg.v;
        pxx[0] = t1_reg.vvq;
        px[1]  = t1_reg.e;
        pxx[1] = sqq[1];
        px[2]  = t1_reg.d;
        pxx[2] = sqq[2];
        ov2_next = t1_reg.ov | sat_ov(c15_w);
        for (int i = 0; i < 3; i++)
        begin
            poly_w[i] = ONE_W + 3 * wide_t'(px[i]) + ((9 * wide_t'(pxx[i])) >>> 1)
                        - wide_t'(c15);
            ov2_next  = ov2_next | sat_ov(poly_w[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                poly_reg[i] <= sat32(poly_w[i]);
            rho2_reg <= t1_reg.rho;
            ov2_reg  <= ov2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= 64'(rho2_reg) * 64'(poly_reg[i]);
            ov3_reg <= ov2_reg;
        end
    end

    // Lane 0 divides by nine, lanes 1 and 2 by thirty-six (a quarter first).
    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        localparam int SH = (l == 0) ? 0 : 2;

        logic signed [MULQ_W-1:0] x;
        logic [MULQ_W-1:0]        mag;
        logic [34:0]              y;
        logic [69:0]              full;
        logic [31:0]              q;

        assign x    = qtrunc(prod_reg[l]);
        assign mag  = x[MULQ_W-1] ? MULQ_W'(-x) : MULQ_W'(x);
        assign y    = 35'(mag >> SH);
        assign full = (70'(ph_reg[l]) << SPLIT) + 70'(pl_reg[l]);
        assign q    = full[RECIP_SHIFT +: 32];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ph_reg[l]  <= 52'(y[34:SPLIT]) * 52'(RECIP9);
                pl_reg[l]  <= 53'(y[SPLIT-1:0]) * 53'(RECIP9);
                neg_reg[l] <= x[MULQ_W-1];
                res_reg[l] <= neg_reg[l] ? 32'(-q) : q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ov4_reg <= ov3_reg;
            ov5_reg <= ov4_reg;
        end
    end

    assign out_valid = vld_reg[4];
    assign f_normal  = res_reg[0];
    assign f_east    = res_reg[1];
    assign f_west    = res_reg[2];
    assign ov        = ov5_reg;

endmodule

@@ rtl/lbmw_chk.sv @@
// Port-level checker for the wall closure, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module lbmw_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        node_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_normal,
    input logic [31:0] res_east,
    input logic [31:0] res_west,
    input logic        res_ov
);

    // A stalled result transaction stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result transaction dropped while stalled");

    // A stalled result transaction keeps its payload.
    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable({res_normal, res_east, res_west, res_ov}))
        else $error("result payload changed while stalled");

    // The node side only backs up behind a stalled result.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !node_ready |-> res_valid && !res_ready)
        else $error("node channel stalled without a stalled result");

    // The pipeline comes out of reset empty.
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !res_valid)
        else $error("result offered straight out of reset");

endmodule

bind lbm_moving_wall_closure lbmw_chk u_lbmw_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .node_ready (node.ready),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_normal (result.f_normal_in),
    .res_east   (result.f_diag_in_east),
    .res_west   (result.f_diag_in_west),
    .res_ov     (result.overflow)
);
